/* design/inbt_pkg.sv */
// Shared types and codes for the net bounding box tracker.
package inbt_pkg;

  localparam int DEF_NET_COUNT       = 1024;
  localparam int DEF_COORD_BITS      = 10;
  localparam int DEF_EDGE_COUNT_BITS = 8;

  localparam logic [2:0] CMD_BUILD   = 3'd0;
  localparam logic [2:0] CMD_MOVE    = 3'd1;
  localparam logic [2:0] CMD_REBUILD = 3'd2;
  localparam logic [2:0] CMD_COST    = 3'd3;
  localparam logic [2:0] CMD_COMMIT  = 3'd4;
  localparam logic [2:0] CMD_REVERT  = 3'd5;

  localparam logic [1:0] MK_NONE = 2'd0;
  localparam logic [1:0] MK_OUT  = 2'd1;
  localparam logic [1:0] MK_IN   = 2'd2;
  localparam logic [1:0] MK_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] net_index;
    logic       first_pin;
    logic [9:0] old_x;
    logic [9:0] old_y;
    logic [9:0] new_x;
    logic [9:0] new_y;
  } in_word_t;

  typedef struct packed {
    logic signed [11:0] hpwl_delta;
    logic [1:0]         change_x;
    logic [1:0]         change_y;
  } out_word_t;

endpackage

/* design/incremental_net_bbox_tracker.sv */
// Net bounding box tracker: committed and tentative box tables with change marks.
//
//   channel | ports                 | handshake
//   --------+-----------------------+-----------------------------------------
//   input   | start, busy, in_word  | word taken at edge with start & !busy
//   result  | out_valid, out_word   | one-cycle strobe, receiver cannot stall
//
// One word per cycle when not busy: one read-modify-write of a single net entry per command.
// The accepted word is registered into the execute stage, and the result strobe is registered from it.
// Back-to-back words to the same net are forwarded from the write port to the execute stage.
// After reset busy stays high while every entry of the mark/tentative memory
// is swept to zero, one entry per cycle. After that busy stays low.
module incremental_net_bbox_tracker #(
  parameter int NET_COUNT       = inbt_pkg::DEF_NET_COUNT,
  parameter int COORD_BITS      = inbt_pkg::DEF_COORD_BITS,
  parameter int EDGE_COUNT_BITS = inbt_pkg::DEF_EDGE_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  inbt_pkg::in_word_t  in_word,
  output logic                out_valid,
  output inbt_pkg::out_word_t out_word
);

  localparam int ADDR_W = $clog2(NET_COUNT);
  localparam int CW     = COORD_BITS;
  localparam int KW     = EDGE_COUNT_BITS;
  localparam int DW     = COORD_BITS + 3;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NET_COUNT - 1);

  // edge index: 0 x0, 1 x1, 2 y0, 3 y1
  typedef struct packed {
    logic [3:0][CW-1:0] e;
    logic [3:0][KW-1:0] n;
  } box_t;

  typedef struct packed {
    logic [1:0] mk_x;
    logic [1:0] mk_y;
    box_t       box;
  } tent_t;

  typedef struct packed {
    logic [CW-1:0] e;
    logic [KW-1:0] n;
    logic [1:0]    mk;
  } edge_st_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  function automatic logic [KW-1:0] inc_sat(input logic [KW-1:0] c);
    return (c == {KW{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic box_t box_add(input box_t b, input logic [CW-1:0] x,
                                   input logic [CW-1:0] y, input logic first);
    box_t          r;
    logic [CW-1:0] p;
    int            lo;
    int            hi;
    r = b;
    if (first) begin
      r.e = {y, y, x, x};
      r.n = {4{KW'(1)}};
    end else begin
      for (int a = 0; a < 2; a++) begin
        p  = (a == 0) ? x : y;
        lo = 2 * a;
        hi = 2 * a + 1;
        if (b.e[lo] == p) begin
          r.n[lo] = inc_sat(b.n[lo]);
        end else if (p < b.e[lo]) begin
          r.e[lo] = p;
          r.n[lo] = KW'(1);
        end
        if (b.e[hi] == p) begin
          r.n[hi] = inc_sat(b.n[hi]);
        end else if (p > b.e[hi]) begin
          r.e[hi] = p;
          r.n[hi] = KW'(1);
        end
      end
    end
    return r;
  endfunction

  // dir 0: low edge, dir 1: high edge
  function automatic edge_st_t edge_move(input edge_st_t s, input logic [CW-1:0] oc,
                                         input logic [CW-1:0] nc, input logic dir);
    edge_st_t r;
    logic     beyond;
    logic     old_in;
    logic     new_in;
    r      = s;
    beyond = dir ? (nc > s.e) : (nc < s.e);
    old_in = dir ? (oc < s.e) : (oc > s.e);
    new_in = dir ? (nc < s.e) : (nc > s.e);
    if (beyond) begin
      r.e = nc;
      r.n = KW'(1);
      if (s.mk == inbt_pkg::MK_NONE) r.mk = inbt_pkg::MK_OUT;
    end else if (nc == s.e && old_in) begin
      r.n = inc_sat(s.n);
      if (s.mk == inbt_pkg::MK_NONE) r.mk = inbt_pkg::MK_OUT;
    end else if (oc == s.e && new_in) begin
      if (s.n == KW'(1)) begin
        r.mk = inbt_pkg::MK_FULL;
      end else begin
        if (s.n != '0) r.n = s.n - 1'b1;
        if (s.mk == inbt_pkg::MK_NONE) r.mk = inbt_pkg::MK_IN;
      end
    end
    return r;
  endfunction

  // committed boxes, and tentative boxes with their marks
  box_t  mem_a [NET_COUNT];
  tent_t mem_b [NET_COUNT];

  state_t              state_r;
  logic [ADDR_W-1:0]   clr_r;
  logic                acc;
  logic [ADDR_W-1:0]   addr_in;

  logic                v1_r;
  inbt_pkg::in_word_t  req_r;
  logic                inrange_r;
  logic [ADDR_W-1:0]   addr_r;
  box_t                rd_a_r;
  tent_t               rd_b_r;
  logic                fwd_a_r;
  logic                fwd_b_r;
  box_t                fwd_a_data_r;
  tent_t               fwd_b_data_r;

  box_t                ca;
  tent_t               tb;
  box_t                wa;
  tent_t               wb;
  logic                we_a;
  logic                we_b;
  logic                ok;
  logic [CW-1:0]       ox, oy, nx, ny;
  edge_st_t            s_lo, s_hi;
  logic signed [DW-1:0] ht, hc, dl;
  logic signed [31:0]  dw;
  logic signed [11:0]  dsat;

  logic                memb_we;
  logic [ADDR_W-1:0]   memb_addr;
  tent_t               memb_din;

  logic                out_valid_nxt;
  inbt_pkg::out_word_t out_word_nxt;

  assign busy    = (state_r == ST_CLEAR);
  assign acc     = start && !busy;
  assign addr_in = ADDR_W'(in_word.net_index);

  // execute stage
  always_comb begin
    ca   = fwd_a_r ? fwd_a_data_r : rd_a_r;
    tb   = fwd_b_r ? fwd_b_data_r : rd_b_r;
    ox   = CW'(req_r.old_x);
    oy   = CW'(req_r.old_y);
    nx   = CW'(req_r.new_x);
    ny   = CW'(req_r.new_y);
    wa   = ca;
    wb   = tb;
    we_a = 1'b0;
    we_b = 1'b0;
    s_lo = '0;
    s_hi = '0;
    ht   = DW'(tb.box.e[1]) - DW'(tb.box.e[0]) + DW'(tb.box.e[3]) - DW'(tb.box.e[2]);
    hc   = DW'(ca.e[1]) - DW'(ca.e[0]) + DW'(ca.e[3]) - DW'(ca.e[2]);
    dl   = '0;
    ok   = v1_r && inrange_r && (req_r.cmd <= inbt_pkg::CMD_REVERT);
    unique case (req_r.cmd)
      inbt_pkg::CMD_BUILD: begin
        wa      = box_add(ca, nx, ny, req_r.first_pin);
        wb.box  = wa;
        wb.mk_x = inbt_pkg::MK_NONE;
        wb.mk_y = inbt_pkg::MK_NONE;
        we_a    = 1'b1;
        we_b    = 1'b1;
      end
      inbt_pkg::CMD_MOVE: begin
        if (tb.mk_x != inbt_pkg::MK_FULL) begin
          s_lo = edge_move({tb.box.e[0], tb.box.n[0], tb.mk_x}, ox, nx, 1'b0);
          s_hi = edge_move({tb.box.e[1], tb.box.n[1], s_lo.mk}, ox, nx, 1'b1);
          wb.box.e[0] = s_lo.e;
          wb.box.n[0] = s_lo.n;
          wb.box.e[1] = s_hi.e;
          wb.box.n[1] = s_hi.n;
          wb.mk_x     = s_hi.mk;
        end
        if (tb.mk_y != inbt_pkg::MK_FULL) begin
          s_lo = edge_move({tb.box.e[2], tb.box.n[2], tb.mk_y}, oy, ny, 1'b0);
          s_hi = edge_move({tb.box.e[3], tb.box.n[3], s_lo.mk}, oy, ny, 1'b1);
          wb.box.e[2] = s_lo.e;
          wb.box.n[2] = s_lo.n;
          wb.box.e[3] = s_hi.e;
          wb.box.n[3] = s_hi.n;
          wb.mk_y     = s_hi.mk;
        end
        we_b = 1'b1;
      end
      inbt_pkg::CMD_REBUILD: begin
        wb.box = box_add(tb.box, nx, ny, req_r.first_pin);
        if (tb.mk_x == inbt_pkg::MK_FULL) wb.mk_x = inbt_pkg::MK_IN;
        if (tb.mk_y == inbt_pkg::MK_FULL) wb.mk_y = inbt_pkg::MK_IN;
        we_b = 1'b1;
      end
      inbt_pkg::CMD_COST: begin
        dl = ht - hc;
      end
      inbt_pkg::CMD_COMMIT: begin
        wa      = tb.box;
        wb.mk_x = inbt_pkg::MK_NONE;
        wb.mk_y = inbt_pkg::MK_NONE;
        we_a    = 1'b1;
        we_b    = 1'b1;
      end
      inbt_pkg::CMD_REVERT: begin
        wb.box  = ca;
        wb.mk_x = inbt_pkg::MK_NONE;
        wb.mk_y = inbt_pkg::MK_NONE;
        we_b    = 1'b1;
      end
      default: begin
      end
    endcase
    we_a = we_a && ok;
    we_b = we_b && ok;

    dw = 32'(dl);
    if (dw > 32'sd2047) begin
      dsat = 12'sd2047;
    end else if (dw < -32'sd2048) begin
      dsat = -12'sd2048;
    end else begin
      dsat = dw[11:0];
    end

    out_valid_nxt = v1_r;
    if (ok) begin
      out_word_nxt = '{hpwl_delta: dsat, change_x: wb.mk_x, change_y: wb.mk_y};
    end else begin
      out_word_nxt = '0;
    end
  end

  // clearing sweep owns the tentative/mark write port until it finishes
  always_comb begin
    memb_we   = busy ? 1'b1 : we_b;
    memb_addr = busy ? clr_r : addr_r;
    memb_din  = busy ? '0 : wb;
  end

  always_ff @(posedge clk) begin
    if (we_a) mem_a[addr_r] <= wa;
    if (memb_we) mem_b[memb_addr] <= memb_din;
    if (acc) begin
      rd_a_r <= mem_a[addr_in];
      rd_b_r <= mem_b[addr_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      v1_r      <= 1'b0;
      fwd_a_r   <= 1'b0;
      fwd_b_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_nxt;
      v1_r      <= acc;
      fwd_a_r   <= acc && we_a && (addr_in == addr_r);
      fwd_b_r   <= acc && we_b && (addr_in == addr_r);
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == LAST_ADDR) state_r <= ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word     <= out_word_nxt;
    fwd_a_data_r <= wa;
    fwd_b_data_r <= wb;
    if (acc) begin
      req_r     <= in_word;
      addr_r    <= addr_in;
      inrange_r <= 32'(in_word.net_index) < NET_COUNT;
    end
  end

`ifndef ASSERT_OFF
  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) && $past(state_r == ST_CLEAR) |-> !out_valid)
    else $error("result strobe during memory sweep");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> out_valid)
    else $error("accepted word produced no result");

  a_fwd_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_a_r || fwd_b_r) |-> v1_r)
    else $error("forward flag without an executing word");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !we_a && !v1_r)
    else $error("table update while sweep runs");

  a_bad_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !ok |=> out_word == '0)
    else $error("rejected word gave nonzero result");
`endif

endmodule

/* sim/tb_incremental_net_bbox_tracker.sv */
// Self-checking testbench for the net bounding box tracker, with a local box table predictor.
module tb_incremental_net_bbox_tracker;

  localparam int NETS = inbt_pkg::DEF_NET_COUNT;
  localparam int CNT_BITS = inbt_pkg::DEF_EDGE_COUNT_BITS;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam int MAX_PINS = 8;
  localparam int POOL = 12;
  localparam int RANDOM_WORDS = 320;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;
  localparam logic [9:0] COORD_MAX = 10'h3FF;

  typedef logic [9:0] coord_t;
  typedef logic [CNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [3:0][9:0] bound;  // x0, x1, y0, y1
    logic [3:0][CNT_BITS-1:0] cnt;
  } box_t;

  typedef struct {
    inbt_pkg::in_word_t word;
    int                 gap;
    bit                 drain;
  } cmd_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  inbt_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  inbt_pkg::out_word_t out_word;

  incremental_net_bbox_tracker uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_word(out_word)
  );

  always #1 clk = ~clk;

  // Box table mirror
  box_t       committed_box [NETS];
  box_t       tentative_box [NETS];
  logic [1:0] mark_x [NETS];
  logic [1:0] mark_y [NETS];

  inbt_pkg::out_word_t delta_marks_q [$];
  cmd_item_t           cmd_q [$];
  int                  fail_count = 0;

  // Stimulus bookkeeping: nets that were built and where their pins sit
  bit     built [NETS];
  coord_t pin_cx [NETS][MAX_PINS];
  coord_t pin_cy [NETS][MAX_PINS];
  coord_t pin_tx [NETS][MAX_PINS];
  coord_t pin_ty [NETS][MAX_PINS];
  int     pin_n [NETS];
  int     net_pool [POOL];
  int     idle_mode = 0;
  bit     drain_next = 1'b0;
  int     issued = 0;

  function automatic count_t cnt_up(count_t c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic box_t add_pin(box_t b, coord_t x, coord_t y, logic first);
    box_t   r;
    coord_t p;
    int     lo;
    r = b;
    if (first) begin
      r.bound = {y, y, x, x};
      r.cnt = {4{count_t'(1)}};
      return r;
    end
    for (int a = 0; a < 2; a++) begin
      p = (a == 0) ? x : y;
      lo = 2 * a;
      if (r.bound[lo] == p) begin
        r.cnt[lo] = cnt_up(r.cnt[lo]);
      end else if (p < r.bound[lo]) begin
        r.bound[lo] = p;
        r.cnt[lo] = count_t'(1);
      end
      if (r.bound[lo+1] == p) begin
        r.cnt[lo+1] = cnt_up(r.cnt[lo+1]);
      end else if (p > r.bound[lo+1]) begin
        r.bound[lo+1] = p;
        r.cnt[lo+1] = count_t'(1);
      end
    end
    return r;
  endfunction

  function automatic void move_side(inout coord_t pos, inout count_t cnt,
                                    inout logic [1:0] mk, input coord_t oldc,
                                    input coord_t newc, input bit upper);
    bit beyond;
    bit old_inside;
    bit new_inside;
    beyond = upper ? (newc > pos) : (newc < pos);
    old_inside = upper ? (oldc < pos) : (oldc > pos);
    new_inside = upper ? (newc < pos) : (newc > pos);
    if (beyond) begin
      pos = newc;
      cnt = count_t'(1);
      if (mk == inbt_pkg::MK_NONE) mk = inbt_pkg::MK_OUT;
    end else if (newc == pos && old_inside) begin
      cnt = cnt_up(cnt);
      if (mk == inbt_pkg::MK_NONE) mk = inbt_pkg::MK_OUT;
    end else if (oldc == pos && new_inside) begin
      // last pin leaves the edge: only a full pass can find the new one
      if (cnt == count_t'(1)) begin
        mk = inbt_pkg::MK_FULL;
      end else begin
        if (cnt != 0) cnt = cnt - 1'b1;
        if (mk == inbt_pkg::MK_NONE) mk = inbt_pkg::MK_IN;
      end
    end
  endfunction

  function automatic void move_axis(inout box_t b, inout logic [1:0] mk, input int axis,
                                    input coord_t oldc, input coord_t newc);
    coord_t pos;
    count_t cnt;
    if (mk == inbt_pkg::MK_FULL) return;
    for (int s = 0; s < 2; s++) begin
      pos = b.bound[2*axis+s];
      cnt = b.cnt[2*axis+s];
      move_side(pos, cnt, mk, oldc, newc, s == 1);
      b.bound[2*axis+s] = pos;
      b.cnt[2*axis+s] = cnt;
    end
  endfunction

  function automatic int half_perimeter(box_t b);
    return (int'(b.bound[1]) - int'(b.bound[0])) + (int'(b.bound[3]) - int'(b.bound[2]));
  endfunction

  function automatic inbt_pkg::out_word_t apply_net_cmd(inbt_pkg::in_word_t w);
    inbt_pkg::out_word_t r;
    box_t                t;
    logic [1:0]          mx;
    logic [1:0]          my;
    int                  n;
    int                  delta;
    r = '0;
    n = int'(w.net_index);
    delta = 0;
    case (w.cmd)
      inbt_pkg::CMD_BUILD: begin
        committed_box[n] = add_pin(committed_box[n], w.new_x, w.new_y, w.first_pin);
        tentative_box[n] = committed_box[n];
        mark_x[n] = inbt_pkg::MK_NONE;
        mark_y[n] = inbt_pkg::MK_NONE;
      end
      inbt_pkg::CMD_MOVE: begin
        t = tentative_box[n];
        mx = mark_x[n];
        my = mark_y[n];
        move_axis(t, mx, 0, w.old_x, w.new_x);
        move_axis(t, my, 1, w.old_y, w.new_y);
        tentative_box[n] = t;
        mark_x[n] = mx;
        mark_y[n] = my;
      end
      inbt_pkg::CMD_REBUILD: begin
        tentative_box[n] = add_pin(tentative_box[n], w.new_x, w.new_y, w.first_pin);
        if (mark_x[n] == inbt_pkg::MK_FULL) mark_x[n] = inbt_pkg::MK_IN;
        if (mark_y[n] == inbt_pkg::MK_FULL) mark_y[n] = inbt_pkg::MK_IN;
      end
      inbt_pkg::CMD_COST: begin
        delta = half_perimeter(tentative_box[n]) - half_perimeter(committed_box[n]);
        if (delta > 2047) delta = 2047;
        if (delta < -2048) delta = -2048;
      end
      inbt_pkg::CMD_COMMIT: begin
        committed_box[n] = tentative_box[n];
        mark_x[n] = inbt_pkg::MK_NONE;
        mark_y[n] = inbt_pkg::MK_NONE;
      end
      inbt_pkg::CMD_REVERT: begin
        tentative_box[n] = committed_box[n];
        mark_x[n] = inbt_pkg::MK_NONE;
        mark_y[n] = inbt_pkg::MK_NONE;
      end
      default: return r;
    endcase
    r.hpwl_delta = delta[11:0];
    r.change_x = mark_x[n];
    r.change_y = mark_y[n];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_word(logic [2:0] cmd, int net, logic first, coord_t ox,
                                    coord_t oy, coord_t nx, coord_t ny);
    cmd_item_t s;
    s.word.cmd = cmd;
    s.word.net_index = net[9:0];
    s.word.first_pin = first;
    s.word.old_x = ox;
    s.word.old_y = oy;
    s.word.new_x = nx;
    s.word.new_y = ny;
    case (idle_mode)
      0: s.gap = 0;
      1: s.gap = $urandom_range(0, 17);
      default: s.gap = $urandom_range(0, 2);
    endcase
    s.drain = drain_next;
    drain_next = 1'b0;
    cmd_q.insert(cmd_q.size(), s);
    issued++;
  endfunction

  function automatic coord_t nudge(coord_t c);
    int v;
    if ($urandom_range(0, 7) == 0) return coord_t'($urandom);
    v = int'(c) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  function automatic void copy_pins(int net, bit to_committed);
    for (int i = 0; i < MAX_PINS; i++) begin
      if (to_committed) begin
        pin_cx[net][i] = pin_tx[net][i];
        pin_cy[net][i] = pin_ty[net][i];
      end else begin
        pin_tx[net][i] = pin_cx[net][i];
        pin_ty[net][i] = pin_cy[net][i];
      end
    end
  endfunction

  function automatic void build_net(int net);
    int     k;
    int     span;
    coord_t bx;
    coord_t by;
    coord_t x;
    coord_t y;
    k = $urandom_range(1, MAX_PINS);
    case ($urandom_range(0, 2))
      0: span = 3;
      1: span = 15;
      default: span = 1023;
    endcase
    bx = coord_t'($urandom_range(0, 1023 - span));
    by = coord_t'($urandom_range(0, 1023 - span));
    for (int i = 0; i < k; i++) begin
      x = bx + coord_t'($urandom_range(0, span));
      y = by + coord_t'($urandom_range(0, span));
      pin_cx[net][i] = x;
      pin_cy[net][i] = y;
      pin_tx[net][i] = x;
      pin_ty[net][i] = y;
      push_word(inbt_pkg::CMD_BUILD, net, i == 0, coord_t'($urandom), coord_t'($urandom),
                x, y);
    end
    pin_n[net] = k;
    built[net] = 1'b1;
  endfunction

  // moves, optional rebuild, cost, then commit or revert
  function automatic void move_txn(int net);
    int     m;
    int     i;
    int     which;
    coord_t ox;
    coord_t oy;
    coord_t nx;
    coord_t ny;
    m = $urandom_range(1, 4);
    for (int j = 0; j < m; j++) begin
      i = $urandom_range(0, pin_n[net] - 1);
      ox = pin_tx[net][i];
      oy = pin_ty[net][i];
      which = $urandom_range(0, 2);
      nx = (which == 1) ? ox : nudge(ox);
      ny = (which == 2) ? oy : nudge(oy);
      push_word(inbt_pkg::CMD_MOVE, net, 1'($urandom_range(0, 1)), ox, oy, nx, ny);
      pin_tx[net][i] = nx;
      pin_ty[net][i] = ny;
      if ($urandom_range(0, 5) == 0)
        push_word(inbt_pkg::CMD_COST, net, 1'b0, coord_t'($urandom), '0, '0,
                  coord_t'($urandom));
    end
    if ($urandom_range(0, 1) == 0) begin
      for (int p = 0; p < pin_n[net]; p++)
        push_word(inbt_pkg::CMD_REBUILD, net, p == 0, coord_t'($urandom),
                  coord_t'($urandom), pin_tx[net][p], pin_ty[net][p]);
    end
    push_word(inbt_pkg::CMD_COST, net, 1'b0, '0, '0, '0, '0);
    if ($urandom_range(0, 2) != 0) begin
      push_word(inbt_pkg::CMD_COMMIT, net, 1'b0, '0, '0, '0, '0);
      copy_pins(net, 1'b1);
    end else begin
      push_word(inbt_pkg::CMD_REVERT, net, 1'b0, '0, '0, '0, '0);
      copy_pins(net, 1'b0);
    end
  endfunction

  // any command with random fields on a built net
  function automatic void noise_word(int net);
    logic [2:0] cmd;
    logic       first;
    coord_t     nx;
    coord_t     ny;
    cmd = 3'($urandom_range(0, 7));
    first = 1'($urandom_range(0, 1));
    nx = coord_t'($urandom);
    ny = coord_t'($urandom);
    push_word(cmd, net, first, coord_t'($urandom), coord_t'($urandom), nx, ny);
    if (cmd == inbt_pkg::CMD_BUILD && first) begin
      pin_n[net] = 1;
      pin_cx[net][0] = nx;
      pin_cy[net][0] = ny;
      copy_pins(net, 1'b0);
    end else if (cmd == inbt_pkg::CMD_COMMIT) begin
      copy_pins(net, 1'b1);
    end else if (cmd == inbt_pkg::CMD_REVERT) begin
      copy_pins(net, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------- driver

  bit                 took = 1'b0;  // set at the edge that takes the current word
  bit                 sending = 1'b0;
  bit                 gap_armed = 1'b0;
  int                 gap_left = 0;
  inbt_pkg::in_word_t cur_word = '0;

  always @(negedge clk) begin
    if (took) begin
      took = 1'b0;
      sending = 1'b0;
    end
    if (rst_n && !sending && cmd_q.size() > 0) begin
      if (!gap_armed) begin
        gap_left = cmd_q[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (!cmd_q[0].drain || delta_marks_q.size() == 0) begin
        cur_word = cmd_q[0].word;
        void'(cmd_q.pop_front());
        sending = 1'b1;
        gap_armed = 1'b0;
      end
    end
    start <= sending;
    in_word <= cur_word;
  end

  // ---------------------------------------------------------------- monitor

  inbt_pkg::out_word_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (delta_marks_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          fail_count++;
        end else begin
          want = delta_marks_q.pop_front();
          if (out_word.hpwl_delta !== want.hpwl_delta) begin
            $error("hpwl_delta: expected %0d, got %0d", want.hpwl_delta, out_word.hpwl_delta);
            fail_count++;
          end
          if (out_word.change_x !== want.change_x) begin
            $error("change_x: expected %0d, got %0d", want.change_x, out_word.change_x);
            fail_count++;
          end
          if (out_word.change_y !== want.change_y) begin
            $error("change_y: expected %0d, got %0d", want.change_y, out_word.change_y);
            fail_count++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        delta_marks_q.insert(delta_marks_q.size(), apply_net_cmd(in_word));
        took = 1'b1;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int net;
    int sat_end;
    for (int i = 0; i < NETS; i++) begin
      committed_box[i] = '0;
      tentative_box[i] = '0;
      mark_x[i] = inbt_pkg::MK_NONE;
      mark_y[i] = inbt_pkg::MK_NONE;
    end

    // corner box, full-recompute handling, stale cost, extreme deltas
    idle_mode = 2;
    push_word(inbt_pkg::CMD_BUILD, 0, 1'b1, COORD_MAX, COORD_MAX, '0, '0);
    push_word(inbt_pkg::CMD_BUILD, 0, 1'b0, '0, '0, COORD_MAX, COORD_MAX);
    push_word(inbt_pkg::CMD_COST, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_MOVE, 0, 1'b0, COORD_MAX, COORD_MAX, '0, '0);
    push_word(inbt_pkg::CMD_COST, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_MOVE, 0, 1'b0, '0, '0, 10'd5, 10'd5);
    push_word(inbt_pkg::CMD_REBUILD, 0, 1'b1, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_REBUILD, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_COST, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_COMMIT, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_MOVE, 0, 1'b1, '0, '0, COORD_MAX, COORD_MAX);
    push_word(inbt_pkg::CMD_COST, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_REVERT, 0, 1'b0, '0, '0, '0, '0);
    push_word(CMD_UNUSED_A, 0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    push_word(CMD_UNUSED_B, 0, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_BUILD, 1023, 1'b1, COORD_MAX, COORD_MAX, 10'd512, 10'd512);
    push_word(inbt_pkg::CMD_MOVE, 1023, 1'b0, 10'd512, 10'd512, 10'd512, 10'd512);
    push_word(inbt_pkg::CMD_COST, 1023, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    built[0] = 1'b1;
    pin_n[0] = 2;
    for (int i = 0; i < 2; i++) begin
      pin_cx[0][i] = '0;
      pin_cy[0][i] = '0;
    end
    copy_pins(0, 1'b0);
    built[1023] = 1'b1;
    pin_n[1023] = 1;
    pin_cx[1023][0] = 10'd512;
    pin_cy[1023][0] = 10'd512;
    copy_pins(1023, 1'b0);

    // pile pins on the low corner until its edge counts saturate, then peel one off
    idle_mode = 0;
    push_word(inbt_pkg::CMD_BUILD, 1, 1'b1, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_BUILD, 1, 1'b0, '0, '0, 10'd9, 10'd9);
    for (int i = 0; i < 260; i++)
      push_word(inbt_pkg::CMD_BUILD, 1, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_MOVE, 1, 1'b0, '0, '0, 10'd4, 10'd4);
    push_word(inbt_pkg::CMD_COST, 1, 1'b0, '0, '0, '0, '0);
    push_word(inbt_pkg::CMD_COMMIT, 1, 1'b0, '0, '0, '0, '0);
    built[1] = 1'b1;
    pin_n[1] = 2;
    pin_cx[1][0] = 10'd4;
    pin_cy[1][0] = 10'd4;
    pin_cx[1][1] = 10'd9;
    pin_cy[1][1] = 10'd9;
    copy_pins(1, 1'b0);
    sat_end = issued;

    net_pool[0] = 0;
    net_pool[1] = 1023;
    net_pool[2] = 1;
    for (int i = 3; i < POOL; i++)
      net_pool[i] = $urandom_range(0, NETS - 1);

    drain_next = 1'b1;
    while (issued < sat_end + RANDOM_WORDS) begin
      idle_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
      net = net_pool[$urandom_range(0, POOL - 1)];
      if (!built[net]) begin
        build_net(net);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: move_txn(net);
          6: build_net(net);
          7, 8: begin
            repeat ($urandom_range(1, 3)) noise_word(net);
          end
          default: begin
            net = $urandom_range(0, NETS - 1);
            build_net(net);
            move_txn(net);
          end
        endcase
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || sending || delta_marks_q.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && delta_marks_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
